FILE: rtl/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and codes of the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_ZERO_FACTOR = 2'd1;
    localparam status_t ST_FETCH_RANGE = 2'd2;
    localparam status_t ST_LOAD_RANGE  = 2'd3;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd2;

    typedef struct packed {
        logic        command;
        logic [15:0] row;
        logic [15:0] column;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        status_t     status;
        logic [15:0] scaled_width;
        logic [15:0] scaled_height;
    } out_item_t;

    typedef struct packed {
        logic [15:0] scale_factor;
        logic [8:0]  source_width;
        logic [8:0]  source_height;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic check;
        logic div_start;
        logic div_step;
        logic addr_calc;
        logic ram_read;
        logic ram_write;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    is_load;
        status_t err;
    } dp_status_t;

endpackage

FILE: rtl/nearest_neighbor_image_scaler_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Nearest-neighbour scaled view of a stored RGB source frame.
// ----------------------------------------------------------------------------
// One request at a time. A load goes through check, store write and
// handoff. A fetch goes through check, the two restoring dividers that work
// out the source row and column one quotient bit per cycle, an address
// step, one registered read of the pixel store and handoff. A request with
// an error status skips the divide and store access. The store holds
// MAX_WIDTH*MAX_HEIGHT pixels and is not cleared: fetch only pixels already
// loaded. Registers: 0 scale_factor (Q8.8 by default), 1 source_width,
// 2 source_height; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
module nearest_neighbor_image_scaler_top
    import nnis_pkg::*;
    #(
        parameter int MAX_WIDTH        = 256,
        parameter int MAX_HEIGHT       = 256,
        parameter int FACTOR_FRAC_BITS = 8
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        in_valid,
        output logic        in_stall,
        input  in_item_t    in_data,
        output logic        out_valid,
        input  logic        out_stall,
        output out_item_t   out_data,
        input  logic        psel,
        input  logic        penable,
        input  logic        pwrite,
        input  logic [3:0]  paddr,
        input  logic [31:0] pwdata,
        output logic [31:0] prdata,
        output logic        pready
    );

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [1:0] reg_index;
    dp_cmd_t    cmd;
    dp_status_t st;

    // configuration registers
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_factor  <= 16'd256;
            cfg_reg.source_width  <= 9'd256;
            cfg_reg.source_height <= 9'd256;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_SCALE_FACTOR:  cfg_reg.scale_factor  <= pwdata[15:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= pwdata[8:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_index)
            REG_SCALE_FACTOR:  prdata = 32'(cfg_reg.scale_factor);
            REG_SOURCE_WIDTH:  prdata = 32'(cfg_reg.source_width);
            REG_SOURCE_HEIGHT: prdata = 32'(cfg_reg.source_height);
            default:           prdata = 32'd0;
        endcase
    end

    nnis_ctrl #(.DIV_STEPS(16 + FACTOR_FRAC_BITS)) u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .st        (st),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    nnis_datapath
        #(
            .MAX_WIDTH        (MAX_WIDTH),
            .MAX_HEIGHT       (MAX_HEIGHT),
            .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
        )
        u_dp
        (
            .clk      (clk),
            .cfg      (cfg_reg),
            .in_data  (in_data),
            .cmd      (cmd),
            .st       (st),
            .out_data (out_data)
        );

    // busy after accepting a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while not idle afterwards");

    // zero factor status only with a zero factor register
    a_zero_factor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_ZERO_FACTOR) |-> (cfg_reg.scale_factor == 16'd0))
        else $error("zero factor status with non-zero factor");

    // a new result follows a request in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised with no request in flight");

    // errored results carry a zero pixel
    a_error_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_OK) |->
            (out_data.out_red == 8'd0) && (out_data.out_green == 8'd0)
            && (out_data.out_blue == 8'd0))
        else $error("error result with non-zero pixel");

endmodule

FILE: rtl/nnis_ram.sv
// ----------------------------------------------------------------------------
// nnis_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nnis_ram
    #(
        parameter int WIDTH = 24,
        parameter int DEPTH = 65536
    )
    (
        input  logic                                   clk,
        input  logic                                   we,
        input  logic                                   re,
        input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
        input  logic [WIDTH-1:0]                       wdata,
        output logic [WIDTH-1:0]                       rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/nnis_divider.sv
// ----------------------------------------------------------------------------
// nnis_divider
// Restoring divider lane, one quotient bit per step:
// quotient = (coord << FRAC_BITS) / divisor.
// ----------------------------------------------------------------------------
module nnis_divider
    #(
        parameter int FRAC_BITS = 8
    )
    (
        input  logic                  clk,
        input  logic                  start,
        input  logic                  step,
        input  logic [15:0]           coord,
        input  logic [15:0]           divisor,
        output logic [16+FRAC_BITS-1:0] quotient
    );

    localparam int QW = 16 + FRAC_BITS;

    logic [15:0]   rem_reg;
    logic [15:0]   rem_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [16:0]   trial;
    logic [16:0]   diff;

    // one shift and trial subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[QW-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = {coord, {FRAC_BITS{1'b0}}};
        end
        else if (step)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

FILE: rtl/nnis_datapath.sv
// ----------------------------------------------------------------------------
// nnis_datapath
// Request register, range checks, output size, source position dividers,
// pixel store and result register.
// ----------------------------------------------------------------------------
module nnis_datapath
    import nnis_pkg::*;
    #(
        parameter int MAX_WIDTH        = 256,
        parameter int MAX_HEIGHT       = 256,
        parameter int FACTOR_FRAC_BITS = 8
    )
    (
        input  logic       clk,
        input  cfg_t       cfg,
        input  in_item_t   in_data,
        input  dp_cmd_t    cmd,
        output dp_status_t st,
        output out_item_t  out_data
    );

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZ_W    = $clog2(MAX_DIM + 1);
    localparam int PW      = SZ_W + 16;
    localparam int QW      = 16 + FACTOR_FRAC_BITS;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RIW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // saturate a scaled size to the range 1..65535
    function automatic logic [15:0] sat_size(input logic [PW-1:0] prod);
        logic [PW-1:0] s;
        s = prod >> FACTOR_FRAC_BITS;
        if (s == '0)
        begin
            return 16'd1;
        end
        else if (s > PW'(16'hFFFF))
        begin
            return 16'hFFFF;
        end
        return s[15:0];
    endfunction

    in_item_t      item_reg;
    logic [SZ_W-1:0] ew;
    logic [SZ_W-1:0] eh;
    logic [SZ_W-1:0] ew_reg;
    logic [SZ_W-1:0] eh_reg;
    logic [15:0]   sw_reg;
    logic [15:0]   sh_reg;
    logic [PW-1:0] prod_w;
    logic [PW-1:0] prod_h;
    status_t       err;
    status_t       status_reg;
    logic          fetch_ok_reg;
    logic [QW-1:0] quo_row;
    logic [QW-1:0] quo_col;
    logic [RIW-1:0] src_row;
    logic [CIW-1:0] src_col;
    logic [AW-1:0] addr_reg;
    logic [23:0]   rdata;
    logic [23:0]   pixel;
    out_item_t     out_reg;

    // effective source size: zero counts as one, above the maximum saturates
    always_comb
    begin
        if (cfg.source_width == 9'd0)
        begin
            ew = SZ_W'(1);
        end
        else if (32'(cfg.source_width) > MAX_WIDTH)
        begin
            ew = SZ_W'(MAX_WIDTH);
        end
        else
        begin
            ew = SZ_W'(cfg.source_width);
        end
        if (cfg.source_height == 9'd0)
        begin
            eh = SZ_W'(1);
        end
        else if (32'(cfg.source_height) > MAX_HEIGHT)
        begin
            eh = SZ_W'(MAX_HEIGHT);
        end
        else
        begin
            eh = SZ_W'(cfg.source_height);
        end
    end

    // output size, refreshed every cycle from the registers
    assign prod_w = PW'(ew) * PW'(cfg.scale_factor);
    assign prod_h = PW'(eh) * PW'(cfg.scale_factor);

    always_ff @(posedge clk)
    begin
        ew_reg <= ew;
        eh_reg <= eh;
        sw_reg <= sat_size(prod_w);
        sh_reg <= sat_size(prod_h);
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
    end

    // error checks on the held request
    always_comb
    begin
        err = ST_OK;
        if (item_reg.command == CMD_LOAD)
        begin
            if ((item_reg.row >= 16'(eh_reg)) || (item_reg.column >= 16'(ew_reg)))
            begin
                err = ST_LOAD_RANGE;
            end
        end
        else if (cfg.scale_factor == 16'd0)
        begin
            err = ST_ZERO_FACTOR;
        end
        else if ((item_reg.row >= sh_reg) || (item_reg.column >= sw_reg))
        begin
            err = ST_FETCH_RANGE;
        end
    end

    assign st.is_load = (item_reg.command == CMD_LOAD);
    assign st.err     = err;

    // source position dividers, row and column side by side
    nnis_divider #(.FRAC_BITS(FACTOR_FRAC_BITS)) u_div_row
    (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .coord    (item_reg.row),
        .divisor  (cfg.scale_factor),
        .quotient (quo_row)
    );

    nnis_divider #(.FRAC_BITS(FACTOR_FRAC_BITS)) u_div_col
    (
        .clk      (clk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .coord    (item_reg.column),
        .divisor  (cfg.scale_factor),
        .quotient (quo_col)
    );

    // clamp source position to the last row or column
    always_comb
    begin
        if (quo_row >= QW'(eh_reg))
        begin
            src_row = RIW'(eh_reg - SZ_W'(1));
        end
        else
        begin
            src_row = RIW'(quo_row);
        end
        if (quo_col >= QW'(ew_reg))
        begin
            src_col = CIW'(ew_reg - SZ_W'(1));
        end
        else
        begin
            src_col = CIW'(quo_col);
        end
    end

    // status and store address
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            status_reg   <= err;
            fetch_ok_reg <= (item_reg.command == CMD_FETCH) && (err == ST_OK);
            addr_reg     <= AW'(RIW'(item_reg.row) * MAX_WIDTH) + AW'(CIW'(item_reg.column));
        end
        else if (cmd.addr_calc)
        begin
            addr_reg <= AW'(src_row * MAX_WIDTH) + AW'(src_col);
        end
    end

    // pixel store
    nnis_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_store
    (
        .clk   (clk),
        .we    (cmd.ram_write),
        .re    (cmd.ram_read),
        .addr  (addr_reg),
        .wdata ({item_reg.in_red, item_reg.in_green, item_reg.in_blue}),
        .rdata (rdata)
    );

    assign pixel = fetch_ok_reg ? rdata : 24'd0;

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.out_red       <= pixel[23:16];
            out_reg.out_green     <= pixel[15:8];
            out_reg.out_blue      <= pixel[7:0];
            out_reg.status        <= status_reg;
            out_reg.scaled_width  <= sw_reg;
            out_reg.scaled_height <= sh_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/nnis_ctrl.sv
// ----------------------------------------------------------------------------
// nnis_ctrl
// Sequencer: accept, check, divide, address, store access, result handoff.
// ----------------------------------------------------------------------------
module nnis_ctrl
    import nnis_pkg::*;
    #(
        parameter int DIV_STEPS = 24
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       in_valid,
        input  logic       out_stall,
        input  dp_status_t st,
        output logic       in_stall,
        output logic       out_valid,
        output dp_cmd_t    cmd
    );

    localparam int CW = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.err != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else if (st.is_load)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                cmd.addr_calc = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.ram_read = 1'b1;
                state_next   = S_DONE;
            end
            S_WRITE:
            begin
                cmd.ram_write = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: tb/sv/nearest_neighbor_image_scaler_top_tb.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top_tb
// Self-checking bench for the nearest-neighbour image scaler.
// A queue of load and fetch requests feeds a driver that idles at random; a
// monitor predicts each accepted request against its own copy of the source
// frame and registers, and compares every result field by field. Phases walk
// through factors, frame sizes and stall patterns, one with a long hold-off.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_top_tb;
    import nnis_pkg::*;

    localparam int MAX_W     = 256;
    localparam int MAX_H     = 256;
    localparam int FRAC      = 8;
    localparam int LIMIT     = 3000;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL_WAIT = 40;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state: registers, frame contents, and which pixels were loaded
    cfg_t        model_cfg = '{scale_factor: 16'd256, source_width: 9'd256,
                               source_height: 9'd256};
    logic [23:0] model_frame [0:MAX_W*MAX_H-1];
    bit          frame_loaded [0:MAX_W*MAX_H-1];

    in_item_t    scaler_requests [$];
    out_item_t   awaited_results [$];

    bit          in_taken    = 1'b0;
    bit          out_taken   = 1'b0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          idle_cycles = 0;
    int          mismatches  = 0;
    int          result_count = 0;

    nearest_neighbor_image_scaler_top #(
        .MAX_WIDTH       (MAX_W),
        .MAX_HEIGHT      (MAX_H),
        .FACTOR_FRAC_BITS(FRAC)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // zero counts as one, oversize saturates
    function automatic int eff_dim(input logic [8:0] v, input int max_dim);
        if (v == 0)
            return 1;
        return (v > max_dim) ? max_dim : int'(v);
    endfunction

    function automatic int out_dim(input int size);
        longint s;
        s = (longint'(size) * longint'(model_cfg.scale_factor)) >> FRAC;
        if (s == 0)
            s = 1;
        if (s > 65535)
            s = 65535;
        return int'(s);
    endfunction

    function automatic int src_coord(input logic [15:0] coord, input int size);
        longint p;
        p = (longint'(coord) << FRAC) / longint'(model_cfg.scale_factor);
        if (p >= size)
            p = size - 1;
        return int'(p);
    endfunction

    function automatic bit load_in_frame(input logic [15:0] r, input logic [15:0] c);
        return (r < eff_dim(model_cfg.source_height, MAX_H)) &&
               (c < eff_dim(model_cfg.source_width, MAX_W));
    endfunction

    // status of a fetch and, when ok, the frame entry it reads
    function automatic status_t fetch_map(input logic [15:0] r, input logic [15:0] c,
                                          output int addr);
        int ew;
        int eh;
        ew   = eff_dim(model_cfg.source_width, MAX_W);
        eh   = eff_dim(model_cfg.source_height, MAX_H);
        addr = 0;
        if (model_cfg.scale_factor == 0)
            return ST_ZERO_FACTOR;
        if (r >= out_dim(eh) || c >= out_dim(ew))
            return ST_FETCH_RANGE;
        addr = src_coord(r, eh) * MAX_W + src_coord(c, ew);
        return ST_OK;
    endfunction

    function automatic out_item_t scaled_result_for(input in_item_t req);
        out_item_t res;
        int        addr;
        res = '0;
        res.scaled_width  = 16'(out_dim(eff_dim(model_cfg.source_width, MAX_W)));
        res.scaled_height = 16'(out_dim(eff_dim(model_cfg.source_height, MAX_H)));
        if (req.command == CMD_LOAD)
        begin
            if (load_in_frame(req.row, req.column))
                model_frame[int'(req.row) * MAX_W + int'(req.column)] =
                    {req.in_red, req.in_green, req.in_blue};
            else
                res.status = ST_LOAD_RANGE;
        end
        else
        begin
            res.status = fetch_map(req.row, req.column, addr);
            if (res.status == ST_OK)
                {res.out_red, res.out_green, res.out_blue} = model_frame[addr];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with no request outstanding: %h",
                         result_count, got);
        end
        else
        begin
            want = awaited_results.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.status !== want.status ||
                got.scaled_width !== want.scaled_width ||
                got.scaled_height !== want.scaled_height)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("result %0d: expected rgb %h %h %h status %0d size %0dx%0d, ",
                           result_count, want.out_red, want.out_green, want.out_blue,
                           want.status, want.scaled_width, want.scaled_height);
                    $display("got rgb %h %h %h status %0d size %0dx%0d",
                             got.out_red, got.out_green, got.out_blue, got.status,
                             got.scaled_width, got.scaled_height);
                end
            end
        end
        result_count++;
    endtask

    // acceptance, prediction, checking and the stall watchdog
    always @(posedge clk)
    begin
        in_taken  = rst_n && in_valid && (in_stall === 1'b0);
        out_taken = rst_n && (out_valid === 1'b1) && !out_stall;
        if (in_taken)
            awaited_results.push_back(scaled_result_for(in_data));
        if (out_taken)
            check_result(out_data);
        if (in_taken || out_taken)
            idle_cycles = 0;
        else if (rst_n)
            idle_cycles++;
        if (idle_cycles >= LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver and receiver
    // ------------------------------------------------------------------

    // request driver: payload held until taken
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (scaler_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_data  <= scaler_requests.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SCALE_FACTOR:  model_cfg.scale_factor  = value[15:0];
            REG_SOURCE_WIDTH:  model_cfg.source_width  = value[8:0];
            REG_SOURCE_HEIGHT: model_cfg.source_height = value[8:0];
            default: ;
        endcase
    endtask

    task automatic push_request(input logic cmd, input logic [15:0] r,
                                input logic [15:0] c, input logic [23:0] rgb);
        in_item_t req;
        req.command = cmd;
        req.row     = r;
        req.column  = c;
        {req.in_red, req.in_green, req.in_blue} = rgb;
        if (cmd == CMD_LOAD && load_in_frame(r, c))
            frame_loaded[int'(r) * MAX_W + int'(c)] = 1'b1;
        scaler_requests.push_back(req);
    endtask

    // a fetch that would read a never-loaded pixel gets that pixel loaded first
    task automatic push_fetch(input logic [15:0] r, input logic [15:0] c);
        int addr;
        if (fetch_map(r, c, addr) == ST_OK && !frame_loaded[addr])
            push_request(CMD_LOAD, 16'(addr / MAX_W), 16'(addr % MAX_W),
                         24'($urandom));
        push_request(CMD_FETCH, r, c, 24'($urandom));
    endtask

    task automatic add_random_request();
        int ew;
        int eh;
        int sw;
        int sh;
        int pick;
        ew   = eff_dim(model_cfg.source_width, MAX_W);
        eh   = eff_dim(model_cfg.source_height, MAX_H);
        sw   = out_dim(ew);
        sh   = out_dim(eh);
        pick = $urandom_range(99);
        if (pick < 30)
            push_request(CMD_LOAD, 16'($urandom_range(eh - 1)),
                         16'($urandom_range(ew - 1)), 24'($urandom));
        else if (pick < 38)
            push_request(CMD_LOAD, 16'($urandom), 16'($urandom), 24'($urandom));
        else if (pick < 44)
            push_request(CMD_LOAD, 16'(eh - 1 + $urandom_range(1)),
                         16'(ew - 1 + $urandom_range(1)), 24'($urandom));
        else if (pick < 82)
            push_fetch(16'($urandom_range(sh - 1)), 16'($urandom_range(sw - 1)));
        else if (pick < 90)
            push_fetch(16'(sh - 1 + $urandom_range(1)), 16'(sw - 1 + $urandom_range(1)));
        else
            push_fetch(16'($urandom), 16'($urandom));
    endtask

    // every result back and the block quiet before registers change
    task automatic wait_idle();
        do
            @(negedge clk);
        while (scaler_requests.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] factor, input logic [8:0] width,
                             input logic [8:0] height, input int count,
                             input int idle, input int stall, input bit long_hold);
        wait_idle();
        write_reg(REG_SCALE_FACTOR, 32'(factor));
        write_reg(REG_SOURCE_WIDTH, 32'(width));
        write_reg(REG_SOURCE_HEIGHT, 32'(height));
        @(posedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        if (long_hold)
            hold_req = 1'b1;
        repeat (count) add_random_request();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: frame corners and range limits at the reset settings
        push_request(CMD_LOAD, 0, 0, 24'hffffff);
        push_request(CMD_LOAD, 255, 255, 24'h000000);
        push_request(CMD_LOAD, 255, 0, 24'h814224);
        push_request(CMD_LOAD, 0, 255, 24'h7ebddb);
        push_request(CMD_LOAD, 256, 0, 24'h123456);
        push_request(CMD_LOAD, 0, 256, 24'h654321);
        push_request(CMD_LOAD, 16'hffff, 16'hffff, 24'hffffff);
        push_fetch(0, 0);
        push_fetch(255, 255);
        push_fetch(255, 0);
        push_fetch(0, 255);
        push_fetch(256, 0);
        push_fetch(0, 256);
        push_fetch(16'hffff, 16'hffff);
        wait_idle();

        // zero factor: fetches refused, loads still land
        write_reg(REG_SCALE_FACTOR, 0);
        push_fetch(0, 0);
        push_request(CMD_LOAD, 1, 1, 24'haa55aa);
        push_fetch(16'hffff, 0);
        wait_idle();

        // largest factor, oversize width and zero height
        write_reg(REG_SCALE_FACTOR, 32'h0000ffff);
        write_reg(REG_SOURCE_WIDTH, 511);
        write_reg(REG_SOURCE_HEIGHT, 0);
        push_fetch(254, 16'hfffe);
        push_fetch(255, 0);
        push_fetch(0, 16'hffff);
        push_request(CMD_LOAD, 1, 0, 24'h0f0f0f);
        push_request(CMD_LOAD, 0, 255, 24'hf0f0f0);
        push_fetch(0, 16'hfffe);

        // random phases across factors, frame sizes and stall patterns
        run_phase(16'd256,   9'd16,  9'd16,  90, 0,  0,  1'b0);
        run_phase(16'd512,   9'd8,   9'd12,  90, 57, 0,  1'b0);
        run_phase(16'd128,   9'd32,  9'd20,  90, 0,  57, 1'b0);
        run_phase(16'd384,   9'd5,   9'd7,   90, 36, 36, 1'b0);
        run_phase(16'd0,     9'd10,  9'd10,  60, 0,  0,  1'b0);
        run_phase(16'd1,     9'd256, 9'd256, 60, 57, 0,  1'b0);
        run_phase(16'hffff,  9'd1,   9'd1,   90, 0,  57, 1'b0);
        run_phase(16'hffff,  9'd256, 9'd256, 90, 36, 36, 1'b0);
        run_phase(16'($urandom_range(1023, 1)), 9'($urandom_range(40, 1)),
                  9'($urandom_range(40, 1)), 120, 0, 0, 1'b1);
        run_phase(16'd300,   9'd0,   9'd511, 60, 36, 36, 1'b0);
        run_phase(16'($urandom), 9'($urandom), 9'($urandom), 60, 57, 57, 1'b0);

        wait_idle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
